// File: hdl/mie_pkg.sv
// Shared types, opcodes and constants for the MIPS integer execute block.
package mie_pkg;

    localparam int MEM_WORDS = 4096;
    localparam int MEM_AW    = $clog2(MEM_WORDS);

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_OVERFLOW   = 3'd1,
        ST_TRAP       = 3'd2,
        ST_DIV_ZERO   = 3'd3,
        ST_UNKNOWN    = 3'd4,
        ST_MISALIGNED = 3'd5,
        ST_HALTED     = 3'd6
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE, S_READ_A, S_READ_B, S_EXEC, S_MULDIV, S_LOAD, S_STORE, S_FINISH
    } seq_state_t;

    typedef enum logic [1:0] {MD_MULT, MD_MULTU, MD_DIV, MD_DIVU} md_op_t;

    typedef enum logic [1:0] {MDS_IDLE, MDS_RUN, MDS_FIX} md_state_t;

    typedef enum logic [1:0] {SZ_BYTE, SZ_HALF, SZ_WORD} acc_size_t;

    typedef struct packed {
        logic   start;
        md_op_t op;
    } md_req_t;

    typedef struct packed {
        logic        done;
        logic [31:0] hi;
        logic [31:0] lo;
    } md_rsp_t;

    localparam logic [5:0] OP_SPECIAL = 6'h00;
    localparam logic [5:0] OP_REGIMM  = 6'h01;
    localparam logic [5:0] OP_J       = 6'h02;
    localparam logic [5:0] OP_JAL     = 6'h03;
    localparam logic [5:0] OP_BEQ     = 6'h04;
    localparam logic [5:0] OP_BNE     = 6'h05;
    localparam logic [5:0] OP_BLEZ    = 6'h06;
    localparam logic [5:0] OP_BGTZ    = 6'h07;
    localparam logic [5:0] OP_ADDI    = 6'h08;
    localparam logic [5:0] OP_ADDIU   = 6'h09;
    localparam logic [5:0] OP_SLTI    = 6'h0A;
    localparam logic [5:0] OP_SLTIU   = 6'h0B;
    localparam logic [5:0] OP_ANDI    = 6'h0C;
    localparam logic [5:0] OP_ORI     = 6'h0D;
    localparam logic [5:0] OP_XORI    = 6'h0E;
    localparam logic [5:0] OP_LUI     = 6'h0F;
    localparam logic [5:0] OP_LB      = 6'h20;
    localparam logic [5:0] OP_LH      = 6'h21;
    localparam logic [5:0] OP_LW      = 6'h23;
    localparam logic [5:0] OP_LBU     = 6'h24;
    localparam logic [5:0] OP_LHU     = 6'h25;
    localparam logic [5:0] OP_SB      = 6'h28;
    localparam logic [5:0] OP_SH      = 6'h29;
    localparam logic [5:0] OP_SW      = 6'h2B;

    localparam logic [5:0] FN_SLL   = 6'h00;
    localparam logic [5:0] FN_SRL   = 6'h02;
    localparam logic [5:0] FN_SRA   = 6'h03;
    localparam logic [5:0] FN_SLLV  = 6'h04;
    localparam logic [5:0] FN_SRLV  = 6'h06;
    localparam logic [5:0] FN_SRAV  = 6'h07;
    localparam logic [5:0] FN_JR    = 6'h08;
    localparam logic [5:0] FN_JALR  = 6'h09;
    localparam logic [5:0] FN_MFHI  = 6'h10;
    localparam logic [5:0] FN_MTHI  = 6'h11;
    localparam logic [5:0] FN_MFLO  = 6'h12;
    localparam logic [5:0] FN_MTLO  = 6'h13;
    localparam logic [5:0] FN_MULT  = 6'h18;
    localparam logic [5:0] FN_MULTU = 6'h19;
    localparam logic [5:0] FN_DIV   = 6'h1A;
    localparam logic [5:0] FN_DIVU  = 6'h1B;
    localparam logic [5:0] FN_ADD   = 6'h20;
    localparam logic [5:0] FN_ADDU  = 6'h21;
    localparam logic [5:0] FN_SUB   = 6'h22;
    localparam logic [5:0] FN_SUBU  = 6'h23;
    localparam logic [5:0] FN_AND   = 6'h24;
    localparam logic [5:0] FN_OR    = 6'h25;
    localparam logic [5:0] FN_XOR   = 6'h26;
    localparam logic [5:0] FN_NOR   = 6'h27;
    localparam logic [5:0] FN_SLT   = 6'h2A;
    localparam logic [5:0] FN_SLTU  = 6'h2B;
    localparam logic [5:0] FN_TGE   = 6'h30;
    localparam logic [5:0] FN_TGEU  = 6'h31;
    localparam logic [5:0] FN_TLT   = 6'h32;
    localparam logic [5:0] FN_TLTU  = 6'h33;
    localparam logic [5:0] FN_TEQ   = 6'h34;
    localparam logic [5:0] FN_TNE   = 6'h36;

    localparam logic [4:0] RI_BLTZ   = 5'h00;
    localparam logic [4:0] RI_BGEZ   = 5'h01;
    localparam logic [4:0] RI_TGEI   = 5'h08;
    localparam logic [4:0] RI_TGEIU  = 5'h09;
    localparam logic [4:0] RI_TLTI   = 5'h0A;
    localparam logic [4:0] RI_TLTIU  = 5'h0B;
    localparam logic [4:0] RI_TEQI   = 5'h0C;
    localparam logic [4:0] RI_TNEI   = 5'h0E;
    localparam logic [4:0] RI_BLTZAL = 5'h10;
    localparam logic [4:0] RI_BGEZAL = 5'h11;

    localparam logic [4:0] LINK_REG = 5'd31;

endpackage

// File: hdl/mie_muldiv.sv
// Iterative shift-add multiplier and restoring divider shared by mult and div.
module mie_muldiv
    import mie_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  md_req_t     md_req,
    input  logic [31:0] md_a,
    input  logic [31:0] md_b,
    output md_rsp_t     md_rsp
);

    md_state_t   state_reg, state_next;
    md_op_t      op_reg;
    logic [4:0]  cnt_reg;
    logic [32:0] acc_hi_reg;
    logic [31:0] acc_lo_reg;
    logic [31:0] opnd_reg;
    logic [31:0] aop_reg;
    logic        na_reg;
    logic        nb_reg;
    logic        done_reg;
    logic [31:0] res_hi_reg;
    logic [31:0] res_lo_reg;

    logic        is_mult;
    logic        sgn;
    logic [32:0] mul_sum;
    logic [32:0] mul_sel;
    logic [32:0] div_shift;
    logic        div_ge;
    logic [32:0] div_rem;

    always_comb begin
        is_mult   = (op_reg == MD_MULT) || (op_reg == MD_MULTU);
        mul_sum   = {1'b0, acc_hi_reg[31:0]} + {1'b0, opnd_reg};
        mul_sel   = acc_lo_reg[0] ? mul_sum : {1'b0, acc_hi_reg[31:0]};
        div_shift = {acc_hi_reg[31:0], acc_lo_reg[31]};
        div_ge    = div_shift >= {1'b0, opnd_reg};
        div_rem   = div_ge ? (div_shift - {1'b0, opnd_reg}) : div_shift;
        sgn       = (md_req.op == MD_MULT) || (md_req.op == MD_DIV);
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            MDS_IDLE: begin
                if (md_req.start) begin
                    state_next = MDS_RUN;
                end
            end
            MDS_RUN: begin
                if (cnt_reg == '1) begin
                    state_next = MDS_FIX;
                end
            end
            MDS_FIX:  state_next = MDS_IDLE;
            default:  state_next = MDS_IDLE;
        endcase
    end

    always_comb begin
        md_rsp.done = done_reg;
        md_rsp.hi   = res_hi_reg;
        md_rsp.lo   = res_lo_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= MDS_IDLE;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= (state_reg == MDS_FIX);
        end
    end

    always_ff @(posedge aclk) begin
        unique case (state_reg)
            MDS_IDLE: begin
                op_reg     <= md_req.op;
                cnt_reg    <= '0;
                acc_hi_reg <= '0;
                aop_reg    <= md_a;
                na_reg     <= sgn && md_a[31];
                nb_reg     <= sgn && md_b[31];
                if ((md_req.op == MD_DIV) && md_a[31]) begin
                    acc_lo_reg <= 32'd0 - md_a;
                end else begin
                    acc_lo_reg <= md_a;
                end
                if ((md_req.op == MD_DIV) && md_b[31]) begin
                    opnd_reg <= 32'd0 - md_b;
                end else begin
                    opnd_reg <= md_b;
                end
            end
            MDS_RUN: begin
                cnt_reg <= cnt_reg + 5'd1;
                if (is_mult) begin
                    acc_hi_reg <= {1'b0, mul_sel[32:1]};
                    acc_lo_reg <= {mul_sel[0], acc_lo_reg[31:1]};
                end else begin
                    acc_hi_reg <= div_rem;
                    acc_lo_reg <= {acc_lo_reg[30:0], div_ge};
                end
            end
            MDS_FIX: begin
                case (op_reg)
                    MD_MULT: begin
                        res_hi_reg <= acc_hi_reg[31:0] - (na_reg ? opnd_reg : 32'd0)
                                      - (nb_reg ? aop_reg : 32'd0);
                        res_lo_reg <= acc_lo_reg;
                    end
                    MD_MULTU: begin
                        res_hi_reg <= acc_hi_reg[31:0];
                        res_lo_reg <= acc_lo_reg;
                    end
                    default: begin
                        res_lo_reg <= (na_reg ^ nb_reg) ? (32'd0 - acc_lo_reg) : acc_lo_reg;
                        res_hi_reg <= na_reg ? (32'd0 - acc_hi_reg[31:0]) : acc_hi_reg[31:0];
                    end
                endcase
            end
            default: begin
                cnt_reg <= '0;
            end
        endcase
    end

endmodule

// File: hdl/mips_integer_instruction_execute.sv
// Top level of the MIPS32 integer instruction execute block.
//
// The s_ channel takes one instruction word, executed at the current program
// counter; the m_ channel returns one result word per instruction with the
// next PC, a status code and the register and memory effects.
// The block handles one instruction at a time and s_ready is high only while
// it is idle. An accepted word, unless halted, passes through S_READ_A,
// S_READ_B and S_EXEC, then S_LOAD or S_STORE for loads and stores or S_MULDIV
// for mult and div, whose 32 iterations run on the shared multiply/divide
// unit, and ends in S_FINISH. The block returns to idle as m_valid rises, so
// the next word can be accepted while the result is still held. The two
// register operands come from a one-port register file read in S_READ_A and S_READ_B.
// A finished result waits in the output register while the receiver stalls,
// and the sequencer holds in its final state until that register is free.
// Reset sets the PC to 0x00400000, clears the registers, HI, LO and the halt
// flag; data memory is undefined until stored. A cfg_we write loads the PC.
// After any error status the block halts and answers every later word with
// the halted status until reset.
module mips_integer_instruction_execute
    import mie_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [31:0] cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_instruction,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_next_pc,
    output logic [2:0]  m_status,
    output logic        m_reg_written,
    output logic [4:0]  m_dest_index,
    output logic [31:0] m_dest_value,
    output logic        m_store_done,
    output logic [31:0] m_access_address
);

    seq_state_t state_reg, state_next;

    logic [31:0] pc_reg;
    logic        halted_reg;
    logic [31:0] hi_reg;
    logic [31:0] lo_reg;
    logic [31:0] instr_reg;
    logic [31:0] a_reg;
    logic [31:0] b_reg;

    logic [31:0] rf_mem [32];
    logic [31:0] rf_valid_reg;
    logic [31:0] rf_rdata_reg;
    logic        rf_rvalid_reg;
    logic [4:0]  rf_raddr;
    logic [31:0] rf_rvalue;
    logic        rf_we;

    logic [31:0] dmem [MEM_WORDS];
    logic [31:0] dm_rdata_reg;

    status_t     res_status_reg;
    logic [31:0] res_npc_reg;
    logic        res_wr_reg;
    logic [4:0]  res_di_reg;
    logic [31:0] res_dv_reg;
    logic        res_st_reg;
    logic [31:0] res_addr_reg;
    acc_size_t   res_size_reg;
    logic        res_lsigned_reg;

    logic        m_valid_reg;
    logic [31:0] m_next_pc_reg;
    status_t     m_status_reg;
    logic        m_reg_written_reg;
    logic [4:0]  m_dest_index_reg;
    logic [31:0] m_dest_value_reg;
    logic        m_store_done_reg;
    logic [31:0] m_access_address_reg;

    md_req_t     md_req;
    md_rsp_t     md_rsp;

    logic        in_accept;
    logic        out_free;

    logic [5:0]  op;
    logic [4:0]  rs;
    logic [4:0]  rt;
    logic [4:0]  rd;
    logic [4:0]  sa;
    logic [5:0]  fn;
    logic [31:0] ims;
    logic [31:0] imz;
    logic [31:0] pc4;
    logic [31:0] btgt;
    logic [31:0] jtgt;
    logic [31:0] sum_ab;
    logic [31:0] dif_ab;
    logic [31:0] sum_ai;
    logic        lt_s;
    logic        lt_u;
    logic        lt_si;
    logic        lt_ui;

    status_t     ex_status;
    logic [31:0] ex_npc;
    logic        ex_wr;
    logic [4:0]  ex_di;
    logic [31:0] ex_dv;
    logic        ex_mem;
    logic [31:0] ex_addr;
    logic        ex_load;
    logic        ex_store;
    logic        ex_md;
    md_op_t      ex_md_op;
    acc_size_t   ex_size;
    logic        ex_lsigned;
    logic        ex_hi_we;
    logic        ex_lo_we;

    logic [31:0] ld_lane;
    logic [31:0] ld_value;
    logic [31:0] st_mask;
    logic [31:0] st_data;
    logic [31:0] st_merged;

    assign in_accept = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;
    assign rf_rvalue = rf_rvalid_reg ? rf_rdata_reg : 32'd0;
    assign rf_we     = (state_reg == S_FINISH) && out_free && res_wr_reg;

    always_comb begin
        op     = instr_reg[31:26];
        rs     = instr_reg[25:21];
        rt     = instr_reg[20:16];
        rd     = instr_reg[15:11];
        sa     = instr_reg[10:6];
        fn     = instr_reg[5:0];
        ims    = {{16{instr_reg[15]}}, instr_reg[15:0]};
        imz    = {16'd0, instr_reg[15:0]};
        pc4    = pc_reg + 32'd4;
        btgt   = pc4 + {ims[29:0], 2'b00};
        jtgt   = {pc4[31:28], instr_reg[25:0], 2'b00};
        sum_ab = a_reg + b_reg;
        dif_ab = a_reg - b_reg;
        sum_ai = a_reg + ims;
        lt_s   = $signed(a_reg) < $signed(b_reg);
        lt_u   = a_reg < b_reg;
        lt_si  = $signed(a_reg) < $signed(ims);
        lt_ui  = a_reg < ims;
    end

    always_comb begin
        ex_status  = ST_OK;
        ex_npc     = pc4;
        ex_wr      = 1'b0;
        ex_di      = rt;
        ex_dv      = 32'd0;
        ex_mem     = 1'b0;
        ex_load    = 1'b0;
        ex_store   = 1'b0;
        ex_md      = 1'b0;
        ex_md_op   = MD_MULT;
        ex_size    = SZ_WORD;
        ex_lsigned = 1'b0;
        ex_hi_we   = 1'b0;
        ex_lo_we   = 1'b0;
        unique case (op)
            OP_SPECIAL: begin
                ex_wr = 1'b1;
                ex_di = rd;
                unique case (fn)
                    FN_SLL:  ex_dv = b_reg << sa;
                    FN_SRL:  ex_dv = b_reg >> sa;
                    FN_SRA:  ex_dv = $unsigned($signed(b_reg) >>> sa);
                    FN_SLLV: ex_dv = b_reg << a_reg[4:0];
                    FN_SRLV: ex_dv = b_reg >> a_reg[4:0];
                    FN_SRAV: ex_dv = $unsigned($signed(b_reg) >>> a_reg[4:0]);
                    FN_JR: begin
                        ex_wr  = 1'b0;
                        ex_npc = a_reg;
                    end
                    FN_JALR: begin
                        ex_dv  = pc4;
                        ex_npc = a_reg;
                    end
                    FN_MFHI: ex_dv = hi_reg;
                    FN_MTHI: begin
                        ex_wr    = 1'b0;
                        ex_hi_we = 1'b1;
                    end
                    FN_MFLO: ex_dv = lo_reg;
                    FN_MTLO: begin
                        ex_wr    = 1'b0;
                        ex_lo_we = 1'b1;
                    end
                    FN_MULT, FN_MULTU: begin
                        ex_wr    = 1'b0;
                        ex_md    = 1'b1;
                        ex_md_op = (fn == FN_MULT) ? MD_MULT : MD_MULTU;
                    end
                    FN_DIV, FN_DIVU: begin
                        ex_wr    = 1'b0;
                        ex_md_op = (fn == FN_DIV) ? MD_DIV : MD_DIVU;
                        if (b_reg == 32'd0) begin
                            ex_status = ST_DIV_ZERO;
                        end else begin
                            ex_md = 1'b1;
                        end
                    end
                    FN_ADD: begin
                        ex_dv = sum_ab;
                        if (!(a_reg[31] ^ b_reg[31]) && (a_reg[31] ^ sum_ab[31])) begin
                            ex_status = ST_OVERFLOW;
                        end
                    end
                    FN_ADDU: ex_dv = sum_ab;
                    FN_SUB: begin
                        ex_dv = dif_ab;
                        if ((a_reg[31] ^ b_reg[31]) && (a_reg[31] ^ dif_ab[31])) begin
                            ex_status = ST_OVERFLOW;
                        end
                    end
                    FN_SUBU: ex_dv = dif_ab;
                    FN_AND:  ex_dv = a_reg & b_reg;
                    FN_OR:   ex_dv = a_reg | b_reg;
                    FN_XOR:  ex_dv = a_reg ^ b_reg;
                    FN_NOR:  ex_dv = ~(a_reg | b_reg);
                    FN_SLT:  ex_dv = {31'd0, lt_s};
                    FN_SLTU: ex_dv = {31'd0, lt_u};
                    FN_TGE: begin
                        ex_wr = 1'b0;
                        if (!lt_s) ex_status = ST_TRAP;
                    end
                    FN_TGEU: begin
                        ex_wr = 1'b0;
                        if (!lt_u) ex_status = ST_TRAP;
                    end
                    FN_TLT: begin
                        ex_wr = 1'b0;
                        if (lt_s) ex_status = ST_TRAP;
                    end
                    FN_TLTU: begin
                        ex_wr = 1'b0;
                        if (lt_u) ex_status = ST_TRAP;
                    end
                    FN_TEQ: begin
                        ex_wr = 1'b0;
                        if (a_reg == b_reg) ex_status = ST_TRAP;
                    end
                    FN_TNE: begin
                        ex_wr = 1'b0;
                        if (a_reg != b_reg) ex_status = ST_TRAP;
                    end
                    default: begin
                        ex_wr     = 1'b0;
                        ex_status = ST_UNKNOWN;
                    end
                endcase
            end
            OP_REGIMM: begin
                unique case (rt)
                    RI_BLTZ: if (a_reg[31]) ex_npc = btgt;
                    RI_BGEZ: if (!a_reg[31]) ex_npc = btgt;
                    RI_TGEI:  if (!lt_si) ex_status = ST_TRAP;
                    RI_TGEIU: if (!lt_ui) ex_status = ST_TRAP;
                    RI_TLTI:  if (lt_si) ex_status = ST_TRAP;
                    RI_TLTIU: if (lt_ui) ex_status = ST_TRAP;
                    RI_TEQI:  if (a_reg == ims) ex_status = ST_TRAP;
                    RI_TNEI:  if (a_reg != ims) ex_status = ST_TRAP;
                    RI_BLTZAL, RI_BGEZAL: begin
                        ex_wr = 1'b1;
                        ex_di = LINK_REG;
                        ex_dv = pc4;
                        if (a_reg[31] == (rt == RI_BLTZAL)) ex_npc = btgt;
                    end
                    default: ex_status = ST_UNKNOWN;
                endcase
            end
            OP_J:   ex_npc = jtgt;
            OP_JAL: begin
                ex_wr  = 1'b1;
                ex_di  = LINK_REG;
                ex_dv  = pc4;
                ex_npc = jtgt;
            end
            OP_BEQ:  if (a_reg == b_reg) ex_npc = btgt;
            OP_BNE:  if (a_reg != b_reg) ex_npc = btgt;
            OP_BLEZ: if ((a_reg == 32'd0) || a_reg[31]) ex_npc = btgt;
            OP_BGTZ: if ((a_reg != 32'd0) && !a_reg[31]) ex_npc = btgt;
            OP_ADDI: begin
                ex_wr = 1'b1;
                ex_dv = sum_ai;
                if (!(a_reg[31] ^ ims[31]) && (a_reg[31] ^ sum_ai[31])) begin
                    ex_status = ST_OVERFLOW;
                end
            end
            OP_ADDIU: begin
                ex_wr = 1'b1;
                ex_dv = sum_ai;
            end
            OP_SLTI: begin
                ex_wr = 1'b1;
                ex_dv = {31'd0, lt_si};
            end
            OP_SLTIU: begin
                ex_wr = 1'b1;
                ex_dv = {31'd0, lt_ui};
            end
            OP_ANDI: begin
                ex_wr = 1'b1;
                ex_dv = a_reg & imz;
            end
            OP_ORI: begin
                ex_wr = 1'b1;
                ex_dv = a_reg | imz;
            end
            OP_XORI: begin
                ex_wr = 1'b1;
                ex_dv = a_reg ^ imz;
            end
            OP_LUI: begin
                ex_wr = 1'b1;
                ex_dv = {instr_reg[15:0], 16'd0};
            end
            OP_LB, OP_LBU: begin
                ex_wr      = 1'b1;
                ex_mem     = 1'b1;
                ex_load    = 1'b1;
                ex_size    = SZ_BYTE;
                ex_lsigned = (op == OP_LB);
            end
            OP_LH, OP_LHU: begin
                ex_wr      = 1'b1;
                ex_mem     = 1'b1;
                ex_load    = 1'b1;
                ex_size    = SZ_HALF;
                ex_lsigned = (op == OP_LH);
                if (sum_ai[0]) ex_status = ST_MISALIGNED;
            end
            OP_LW: begin
                ex_wr   = 1'b1;
                ex_mem  = 1'b1;
                ex_load = 1'b1;
                if (sum_ai[1:0] != 2'b00) ex_status = ST_MISALIGNED;
            end
            OP_SB: begin
                ex_mem   = 1'b1;
                ex_store = 1'b1;
                ex_size  = SZ_BYTE;
            end
            OP_SH: begin
                ex_mem   = 1'b1;
                ex_store = 1'b1;
                ex_size  = SZ_HALF;
                if (sum_ai[0]) ex_status = ST_MISALIGNED;
            end
            OP_SW: begin
                ex_mem   = 1'b1;
                ex_store = 1'b1;
                if (sum_ai[1:0] != 2'b00) ex_status = ST_MISALIGNED;
            end
            default: ex_status = ST_UNKNOWN;
        endcase

        ex_addr = ex_mem ? sum_ai : 32'd0;
        if (ex_status != ST_OK) begin
            ex_npc   = pc_reg;
            ex_wr    = 1'b0;
            ex_load  = 1'b0;
            ex_store = 1'b0;
            ex_md    = 1'b0;
            ex_hi_we = 1'b0;
            ex_lo_we = 1'b0;
            if (ex_status != ST_MISALIGNED) ex_addr = 32'd0;
        end
        if (!ex_wr || (ex_di == 5'd0)) begin
            ex_wr = 1'b0;
            ex_di = 5'd0;
            ex_dv = 32'd0;
        end
    end

    always_comb begin
        ld_lane = dm_rdata_reg >> {res_addr_reg[1:0], 3'b000};
        case (res_size_reg)
            SZ_BYTE: ld_value = res_lsigned_reg ? {{24{ld_lane[7]}}, ld_lane[7:0]}
                                                : {24'd0, ld_lane[7:0]};
            SZ_HALF: ld_value = res_lsigned_reg ? {{16{ld_lane[15]}}, ld_lane[15:0]}
                                                : {16'd0, ld_lane[15:0]};
            default: ld_value = dm_rdata_reg;
        endcase
        case (res_size_reg)
            SZ_BYTE: st_mask = 32'h0000_00FF << {res_addr_reg[1:0], 3'b000};
            SZ_HALF: st_mask = 32'h0000_FFFF << {res_addr_reg[1:0], 3'b000};
            default: st_mask = 32'hFFFF_FFFF;
        endcase
        st_data   = b_reg << {res_addr_reg[1:0], 3'b000};
        st_merged = (dm_rdata_reg & ~st_mask) | (st_data & st_mask);
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (in_accept) begin
                    state_next = halted_reg ? S_FINISH : S_READ_A;
                end
            end
            S_READ_A: state_next = S_READ_B;
            S_READ_B: state_next = S_EXEC;
            S_EXEC: begin
                if (ex_md) begin
                    state_next = S_MULDIV;
                end else if (ex_load) begin
                    state_next = S_LOAD;
                end else if (ex_store) begin
                    state_next = S_STORE;
                end else begin
                    state_next = S_FINISH;
                end
            end
            S_MULDIV: begin
                if (md_rsp.done) begin
                    state_next = S_FINISH;
                end
            end
            S_LOAD:   state_next = S_FINISH;
            S_STORE:  state_next = S_FINISH;
            S_FINISH: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default:  state_next = S_IDLE;
        endcase
    end

    always_comb begin
        s_ready      = (state_reg == S_IDLE);
        rf_raddr     = (state_reg == S_IDLE) ? s_instruction[25:21] : rt;
        md_req.start = (state_reg == S_EXEC) && ex_md;
        md_req.op    = ex_md_op;
    end

    mie_muldiv u_muldiv (
        .aclk    (aclk),
        .aresetn (aresetn),
        .md_req  (md_req),
        .md_a    (a_reg),
        .md_b    (b_reg),
        .md_rsp  (md_rsp)
    );

    always_ff @(posedge aclk) begin
        rf_rdata_reg  <= rf_mem[rf_raddr];
        rf_rvalid_reg <= rf_valid_reg[rf_raddr];
        if (rf_we) begin
            rf_mem[res_di_reg] <= res_dv_reg;
        end
    end

    always_ff @(posedge aclk) begin
        dm_rdata_reg <= dmem[sum_ai[2 +: MEM_AW]];
        if (state_reg == S_STORE) begin
            dmem[res_addr_reg[2 +: MEM_AW]] <= st_merged;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            pc_reg       <= 32'h0040_0000;
            halted_reg   <= 1'b0;
            hi_reg       <= 32'd0;
            lo_reg       <= 32'd0;
            rf_valid_reg <= 32'd0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_we) begin
                pc_reg <= cfg_wdata;
            end
            if ((state_reg == S_EXEC) && ex_hi_we) begin
                hi_reg <= a_reg;
            end
            if ((state_reg == S_EXEC) && ex_lo_we) begin
                lo_reg <= a_reg;
            end
            if ((state_reg == S_MULDIV) && md_rsp.done) begin
                hi_reg <= md_rsp.hi;
                lo_reg <= md_rsp.lo;
            end
            if ((state_reg == S_FINISH) && out_free) begin
                m_valid_reg <= 1'b1;
                pc_reg      <= res_npc_reg;
                if (rf_we) begin
                    rf_valid_reg[res_di_reg] <= 1'b1;
                end
                if ((res_status_reg != ST_OK) && (res_status_reg != ST_HALTED)) begin
                    halted_reg <= 1'b1;
                end
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        unique case (state_reg)
            S_IDLE: begin
                instr_reg       <= s_instruction;
                res_status_reg  <= ST_HALTED;
                res_npc_reg     <= pc_reg;
                res_wr_reg      <= 1'b0;
                res_di_reg      <= 5'd0;
                res_dv_reg      <= 32'd0;
                res_st_reg      <= 1'b0;
                res_addr_reg    <= 32'd0;
                res_size_reg    <= SZ_WORD;
                res_lsigned_reg <= 1'b0;
            end
            S_READ_A: a_reg <= rf_rvalue;
            S_READ_B: b_reg <= rf_rvalue;
            S_EXEC: begin
                res_status_reg  <= ex_status;
                res_npc_reg     <= ex_npc;
                res_wr_reg      <= ex_wr;
                res_di_reg      <= ex_di;
                res_dv_reg      <= ex_dv;
                res_st_reg      <= 1'b0;
                res_addr_reg    <= ex_addr;
                res_size_reg    <= ex_size;
                res_lsigned_reg <= ex_lsigned;
            end
            S_LOAD: begin
                res_dv_reg <= res_wr_reg ? ld_value : 32'd0;
            end
            S_STORE: begin
                res_st_reg <= 1'b1;
            end
            default: begin
                res_st_reg <= res_st_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if ((state_reg == S_FINISH) && out_free) begin
            m_next_pc_reg        <= res_npc_reg;
            m_status_reg         <= res_status_reg;
            m_reg_written_reg    <= res_wr_reg;
            m_dest_index_reg     <= res_di_reg;
            m_dest_value_reg     <= res_dv_reg;
            m_store_done_reg     <= res_st_reg;
            m_access_address_reg <= res_addr_reg;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_next_pc        = m_next_pc_reg;
    assign m_status         = m_status_reg;
    assign m_reg_written    = m_reg_written_reg;
    assign m_dest_index     = m_dest_index_reg;
    assign m_dest_value     = m_dest_value_reg;
    assign m_store_done     = m_store_done_reg;
    assign m_access_address = m_access_address_reg;

    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_status != ST_OK)) |-> halted_reg)
        else $error("Error status delivered without the halt flag set.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_reg_written) |-> (m_dest_index != 5'd0))
        else $error("Register zero reported as written.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_store_done) |-> ((m_status == ST_OK) && !m_reg_written))
        else $error("Store reported together with an error or a register write.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        md_rsp.done |-> (state_reg == S_MULDIV))
        else $error("Multiply/divide unit finished outside its wait state.");

endmodule
